### rtl/assert_macros.svh
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

### rtl/ltc_pkg.sv
package ltc_pkg;

  localparam int NUM_KW   = 16;
  localparam int NUM_BOOL = 2;

  localparam logic [3:0] TC_KEYWORD  = 4'd0;
  localparam logic [3:0] TC_OPERATOR = 4'd1;
  localparam logic [3:0] TC_INT      = 4'd2;
  localparam logic [3:0] TC_FLOAT    = 4'd3;
  localparam logic [3:0] TC_CHAR     = 4'd4;
  localparam logic [3:0] TC_STRING   = 4'd5;
  localparam logic [3:0] TC_BOOL     = 4'd6;
  localparam logic [3:0] TC_IDENT    = 4'd7;
  localparam logic [3:0] TC_PREPROC  = 4'd8;
  localparam logic [3:0] TC_COMMENT  = 4'd9;
  localparam logic [3:0] TC_SEP      = 4'd10;
  localparam logic [3:0] TC_INVALID  = 4'd11;

  localparam logic [3:0] LEN_MAX = 4'd15;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_op1(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
           (c == "=") || (c == ">") || (c == "<") || (c == "!") || (c == "&") ||
           (c == "|");
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ";") || (c == ",") || (c == "(") || (c == ")") ||
           (c == "{") || (c == "}") || (c == "[") || (c == "]");
  endfunction

  // Words are right aligned: the last character sits in the low byte.
  function automatic logic [63:0] kw_word(input logic [3:0] idx);
    logic [63:0] w;
    unique case (idx)
      4'd0:    w = 64'("int");
      4'd1:    w = 64'("float");
      4'd2:    w = 64'("char");
      4'd3:    w = 64'("if");
      4'd4:    w = 64'("else");
      4'd5:    w = 64'("while");
      4'd6:    w = 64'("for");
      4'd7:    w = 64'("return");
      4'd8:    w = 64'("break");
      4'd9:    w = 64'("continue");
      4'd10:   w = 64'("void");
      4'd11:   w = 64'("switch");
      4'd12:   w = 64'("case");
      4'd13:   w = 64'("default");
      4'd14:   w = 64'("goto");
      default: w = 64'("sizeof");
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] idx);
    logic [3:0] n;
    unique case (idx)
      4'd0, 4'd6:                      n = 4'd3;
      4'd3:                            n = 4'd2;
      4'd2, 4'd4, 4'd10, 4'd12, 4'd14: n = 4'd4;
      4'd1, 4'd5, 4'd8:                n = 4'd5;
      4'd7, 4'd11, 4'd15:              n = 4'd6;
      4'd13:                           n = 4'd7;
      default:                         n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] bool_word(input logic idx);
    return idx ? 64'("false") : 64'("true");
  endfunction

  function automatic logic [3:0] bool_len(input logic idx);
    return idx ? 4'd5 : 4'd4;
  endfunction

  // Character of a word at a position; no match past the word's end.
  function automatic logic word_hit(input logic [63:0] w, input logic [3:0] n,
                                    input logic [3:0] pos, input logic [7:0] c);
    logic [2:0] k;
    logic       hit;
    k   = 3'(n - pos - 4'd1);
    hit = 1'b0;
    if (pos < n) begin
      hit = (w[{k, 3'b000} +: 8] == c);
    end
    return hit;
  endfunction

endpackage

### rtl/ltc_if.sv
interface ltc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ltc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_class;

  modport source (output valid, output token_class, input ready);
  modport sink   (input valid, input token_class, output ready);
endinterface

### rtl/lexical_token_classifier.sv
// Lexical token classifier.
// in_tok carries one character per transfer (ch) and a flag on the token's
// final character (last). out_cls carries one token_class per token, sent
// for the transfer that has last set; other transfers produce nothing.
// Classes, first match wins: keyword, operator, integer, float, char
// literal, string, boolean, identifier, preprocessor, comment, separator,
// invalid.
// The class appears on out_cls in the cycle after the final character's
// transfer. One character per cycle while out_cls is not stalled;
// per-token state and all class checks are fixed per-position compares
// between the token state registers and the single output register.
// Reset clears the token state and drops out_cls.valid.
// When the receiver stalls, the class is held in the output register and
// in_tok.ready stays low, so no character is taken until the held class is
// taken; a character offered in that cycle is taken along with it.
module lexical_token_classifier (
  input  logic      clk,
  input  logic      rst_n,
  ltc_in_if.sink    in_tok,
  ltc_out_if.source out_cls
);

  logic [3:0]                   len_r,   len_nxt;
  logic [7:0]                   first_r, first_nxt;
  logic [7:0]                   sec_r,   sec_nxt;
  logic [7:0]                   prev_r,  prev_nxt;
  logic [ltc_pkg::NUM_KW-1:0]   kw_r,    kw_nxt;
  logic [ltc_pkg::NUM_BOOL-1:0] bl_r,    bl_nxt;
  logic                         dig_r,   dig_nxt;
  logic                         dd_r,    dd_nxt;
  logic [1:0]                   dots_r,  dots_nxt;
  logic                         id_r,    id_nxt;

  logic                         out_valid_r;
  logic [3:0]                   cls_r, cls_nxt;

  logic                         in_fire;
  logic                         tok_end;
  logic [7:0]                   ch;
  logic [3:0]                   pos, total;
  logic [7:0]                   c0, c1, cprev;
  logic                         kw_any, bl_any, num_start, op2;
  logic [ltc_pkg::NUM_KW-1:0]   kw_len_ok;
  logic [ltc_pkg::NUM_BOOL-1:0] bl_len_ok;

  assign in_tok.ready        = !out_valid_r || out_cls.ready;
  assign in_fire             = in_tok.valid && in_tok.ready;
  assign tok_end             = in_fire && in_tok.last;
  assign out_cls.valid       = out_valid_r;
  assign out_cls.token_class = cls_r;

  assign ch    = in_tok.ch;
  assign pos   = len_r;
  assign total = (pos < ltc_pkg::LEN_MAX) ? pos + 4'd1 : ltc_pkg::LEN_MAX;

  // Running per-token state, as it stands after this character.
  always_comb begin
    for (int i = 0; i < ltc_pkg::NUM_KW; i++) begin
      kw_nxt[i]    = kw_r[i] & ltc_pkg::word_hit(ltc_pkg::kw_word(4'(i)),
                                                 ltc_pkg::kw_len(4'(i)), pos, ch);
      kw_len_ok[i] = (total == ltc_pkg::kw_len(4'(i)));
    end
    for (int i = 0; i < ltc_pkg::NUM_BOOL; i++) begin
      bl_nxt[i]    = bl_r[i] & ltc_pkg::word_hit(ltc_pkg::bool_word(1'(i)),
                                                 ltc_pkg::bool_len(1'(i)), pos, ch);
      bl_len_ok[i] = (total == ltc_pkg::bool_len(1'(i)));
    end

    first_nxt = first_r;
    sec_nxt   = sec_r;
    dig_nxt   = dig_r;
    dd_nxt    = dd_r;
    dots_nxt  = dots_r;
    id_nxt    = id_r;
    if (pos == 4'd0) begin
      first_nxt = ch;
    end else begin
      if (pos == 4'd1) begin
        sec_nxt = ch;
      end
      if (!ltc_pkg::is_digit(ch)) begin
        dig_nxt = 1'b0;
      end
      if (!ltc_pkg::is_digit(ch) && (ch != ".")) begin
        dd_nxt = 1'b0;
      end
      if ((ch == ".") && (dots_r < 2'd2)) begin
        dots_nxt = dots_r + 2'd1;
      end
      if (!(ltc_pkg::is_alpha(ch) || ltc_pkg::is_digit(ch) || (ch == "_"))) begin
        id_nxt = 1'b0;
      end
    end
    prev_nxt = ch;
    len_nxt  = (len_r < ltc_pkg::LEN_MAX) ? len_r + 4'd1 : len_r;
  end

  // Class of a token ending with this character.
  always_comb begin
    c0        = first_nxt;
    c1        = (pos >= 4'd1) ? sec_nxt : 8'd0;
    cprev     = (pos >= 4'd1) ? prev_r  : 8'd0;
    kw_any    = |(kw_nxt & kw_len_ok);
    bl_any    = |(bl_nxt & bl_len_ok);
    num_start = (c0 == "-") || ltc_pkg::is_digit(c0);
    op2       = ((c0 == "=") && (c1 == "=")) || ((c0 == "!") && (c1 == "=")) ||
                ((c0 == "&") && (c1 == "&")) || ((c0 == "|") && (c1 == "|")) ||
                ((c0 == ">") && (c1 == "=")) || ((c0 == "<") && (c1 == "="));

    priority if (kw_any) begin
      cls_nxt = ltc_pkg::TC_KEYWORD;
    end else if (((total == 4'd1) && ltc_pkg::is_op1(c0)) || ((total == 4'd2) && op2)) begin
      cls_nxt = ltc_pkg::TC_OPERATOR;
    end else if (num_start && dig_nxt) begin
      cls_nxt = ltc_pkg::TC_INT;
    end else if (num_start && dd_nxt && (dots_nxt == 2'd1)) begin
      cls_nxt = ltc_pkg::TC_FLOAT;
    end else if ((total == 4'd3) && (c0 == ltc_pkg::CH_SQUOTE) &&
                 (ch == ltc_pkg::CH_SQUOTE)) begin
      cls_nxt = ltc_pkg::TC_CHAR;
    end else if ((c0 == ltc_pkg::CH_DQUOTE) && (ch == ltc_pkg::CH_DQUOTE)) begin
      cls_nxt = ltc_pkg::TC_STRING;
    end else if (bl_any) begin
      cls_nxt = ltc_pkg::TC_BOOL;
    end else if ((ltc_pkg::is_alpha(c0) || (c0 == "_")) && id_nxt) begin
      cls_nxt = ltc_pkg::TC_IDENT;
    end else if (c0 == "#") begin
      cls_nxt = ltc_pkg::TC_PREPROC;
    end else if ((c0 == "/") && ((c1 == "/") || ((c1 == "*") && (total >= 4'd2) &&
                                                 (cprev == "*") && (ch == "/")))) begin
      cls_nxt = ltc_pkg::TC_COMMENT;
    end else if ((total == 4'd1) && ltc_pkg::is_sep(c0)) begin
      cls_nxt = ltc_pkg::TC_SEP;
    end else begin
      cls_nxt = ltc_pkg::TC_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      first_r <= '0;
      sec_r   <= '0;
      prev_r  <= '0;
      kw_r    <= '1;
      bl_r    <= '1;
      dig_r   <= 1'b1;
      dd_r    <= 1'b1;
      dots_r  <= '0;
      id_r    <= 1'b1;
    end else if (in_fire) begin
      if (in_tok.last) begin
        len_r   <= '0;
        first_r <= '0;
        sec_r   <= '0;
        prev_r  <= '0;
        kw_r    <= '1;
        bl_r    <= '1;
        dig_r   <= 1'b1;
        dd_r    <= 1'b1;
        dots_r  <= '0;
        id_r    <= 1'b1;
      end else begin
        len_r   <= len_nxt;
        first_r <= first_nxt;
        sec_r   <= sec_nxt;
        prev_r  <= prev_nxt;
        kw_r    <= kw_nxt;
        bl_r    <= bl_nxt;
        dig_r   <= dig_nxt;
        dd_r    <= dd_nxt;
        dots_r  <= dots_nxt;
        id_r    <= id_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_tok.last) begin
      out_valid_r <= 1'b1;
    end else if (out_cls.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tok.last) begin
      cls_r <= cls_nxt;
    end
  end

`include "assert_macros.svh"

  // Output slot is refilled exactly when a final character is taken.
  `ASSERT_NEXT(a_out_fill, !out_valid_r || out_cls.ready, out_valid_r == $past(tok_end))
  // Length counts up by one per non-final character until it saturates.
  `ASSERT_NEXT(a_len_step, in_fire && !in_tok.last && !(&len_r), len_r == $past(len_r) + 4'd1)
  // A final character leaves the token state at its start values.
  `ASSERT_NEXT(a_tok_clear, tok_end, (len_r == 4'd0) && (kw_r == '1) && (dots_r == 2'd0))
  // Dot count saturates at two.
  `ASSERT_NOW(a_dot_sat, 1'b1, dots_r != 2'd3)

endmodule
